// ----- design/wsfb_pkg.sv -----
// Shared types and constants for the WebSocket frame builder.
// Used by the front, queue, back and top-level modules; no dependencies.
package wsfb_pkg;

  localparam int S_TDATA_W = 112;

  localparam int FIN_POS = 0;
  localparam int RSV1_POS = 1;
  localparam int RSV2_POS = 2;
  localparam int RSV3_POS = 3;
  localparam int OPC_LSB = 4;
  localparam int LEN_LSB = 8;
  localparam int KEY_LSB = 71;
  localparam int DATA_LSB = 103;

  localparam logic FUNC_HEADER = 1'b0;
  localparam logic FUNC_PAYLOAD = 1'b1;

  localparam logic [62:0] LEN_DIRECT_MAX = 63'd125;
  localparam logic [62:0] LEN_16_MAX = 63'd65535;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [3:0] EXT_NONE = 4'd0;
  localparam logic [3:0] EXT_16 = 4'd2;
  localparam logic [3:0] EXT_64 = 4'd8;
  localparam logic [3:0] HDR_BASE = 4'd2;
  localparam logic [3:0] KEY_BYTES = 4'd4;

  typedef struct packed {
    logic        is_payload;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [3:0]  ext_count;
    logic        key_on;
    logic        len_zero;
    logic [62:0] len;
    logic [31:0] key;
  } wsfb_entry_t;

  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] res;
    unique case (idx)
      2'd0: res = key[31:24];
      2'd1: res = key[23:16];
      2'd2: res = key[15:8];
      default: res = key[7:0];
    endcase
    return res;
  endfunction

endpackage

// ----- design/wsfb_front.sv -----
// Front end of the frame builder: accepts items, tracks frame state and
// masks payload bytes, then pushes work entries into the queue. Uses wsfb_pkg.
module wsfb_front import wsfb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  input  logic                 q_full,
  output logic                 push,
  output wsfb_entry_t          push_entry
);

  logic        mask_enable;
  logic [62:0] bytes_remaining;
  logic [1:0]  key_index;
  logic [31:0] held_key;

  logic        accept;
  logic [62:0] hdr_len;
  logic [31:0] hdr_key;
  logic [7:0]  data_byte;
  logic        in_frame;

  assign s_tready = !q_full;
  assign cfg_ready = 1'b1;
  assign accept = s_tvalid && s_tready;
  assign hdr_len = s_tdata[LEN_LSB +: 63];
  assign hdr_key = s_tdata[KEY_LSB +: 32];
  assign data_byte = s_tdata[DATA_LSB +: 8];
  assign in_frame = (bytes_remaining != '0);

  always_comb begin
    push_entry = '0;
    push = 1'b0;
    if (s_tuser == FUNC_PAYLOAD) begin
      push = accept && in_frame;
      push_entry.is_payload = 1'b1;
      push_entry.byte0 = data_byte ^ key_byte(held_key, key_index);
      push_entry.len_zero = (bytes_remaining == 63'd1);
    end else begin
      push = accept;
      push_entry.byte0 = {s_tdata[FIN_POS], s_tdata[RSV1_POS], s_tdata[RSV2_POS],
                          s_tdata[RSV3_POS], s_tdata[OPC_LSB +: 4]};
      if (hdr_len <= LEN_DIRECT_MAX) begin
        push_entry.byte1 = {mask_enable, hdr_len[6:0]};
        push_entry.ext_count = EXT_NONE;
      end else if (hdr_len <= LEN_16_MAX) begin
        push_entry.byte1 = {mask_enable, LEN_CODE_16};
        push_entry.ext_count = EXT_16;
      end else begin
        push_entry.byte1 = {mask_enable, LEN_CODE_64};
        push_entry.ext_count = EXT_64;
      end
      push_entry.key_on = mask_enable;
      push_entry.len_zero = (hdr_len == '0);
      push_entry.len = hdr_len;
      push_entry.key = hdr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_enable <= 1'b0;
      bytes_remaining <= '0;
      key_index <= '0;
      held_key <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mask_enable <= cfg_data;
      end
      if (accept) begin
        if (s_tuser == FUNC_HEADER) begin
          bytes_remaining <= hdr_len;
          key_index <= '0;
          held_key <= mask_enable ? hdr_key : '0;
        end else if (in_frame) begin
          bytes_remaining <= bytes_remaining - 63'd1;
          key_index <= key_index + 2'd1;
        end
      end
    end
  end

  a_hdr_len: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == FUNC_HEADER |=> bytes_remaining == $past(hdr_len))
    else $error("frame length not loaded at header");
  a_key_clear: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == FUNC_HEADER && !mask_enable |=> held_key == '0)
    else $error("key held while masking is off");
  a_drop: assert property (@(posedge clk) disable iff (rst)
    push && push_entry.is_payload |-> bytes_remaining != '0)
    else $error("payload pushed outside a frame");

endmodule

// ----- design/wsfb_queue.sv -----
// Short register queue of work entries between the front and back ends.
// Uses wsfb_pkg for the entry type.
module wsfb_queue import wsfb_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  wsfb_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output wsfb_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  wsfb_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

// ----- design/wsfb_back.sv -----
// Back end of the frame builder: serializes queue entries into output beats
// through a registered output stage. Uses wsfb_pkg.
module wsfb_back import wsfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  wsfb_entry_t head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  output logic        m_tuser
);

  logic [3:0] pos;
  logic [3:0] hdr_count;
  logic [3:0] len_sel;
  logic [3:0] key_sel;
  logic [63:0] len_wide;
  logic       load;
  logic       last;
  logic [7:0] beat_byte;

  assign load = head_valid && (!m_tvalid || m_tready);
  assign hdr_count = HDR_BASE + head.ext_count + (head.key_on ? KEY_BYTES : 4'd0);
  assign last = head.is_payload || (pos == hdr_count - 4'd1);
  assign pop = load && last;
  assign len_wide = {1'b0, head.len};
  assign len_sel = head.ext_count + 4'd1 - pos;
  assign key_sel = pos - HDR_BASE - head.ext_count;

  always_comb begin
    if (head.is_payload || pos == 4'd0) begin
      beat_byte = head.byte0;
    end else if (pos == 4'd1) begin
      beat_byte = head.byte1;
    end else if (pos < HDR_BASE + head.ext_count) begin
      beat_byte = len_wide[{len_sel[2:0], 3'b000} +: 8];
    end else begin
      beat_byte = key_byte(head.key, key_sel[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        pos <= last ? 4'd0 : pos + 4'd1;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= beat_byte;
      m_tlast <= last;
      m_tuser <= last && head.len_zero;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos < 4'd14)
    else $error("header position out of range");
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame end on a beat that is not last of its run");
  a_pos_restart: assert property (@(posedge clk) disable iff (rst) pop |=> pos == 4'd0)
    else $error("position not cleared after entry done");

endmodule

// ----- design/websocket_frame_builder.sv -----
// WebSocket frame builder top level. With an empty queue and a free output stage, an
// accepted item is written into the entry queue and then loaded into the registered
// output stage before its first beat can be taken on the m side. While m_tready holds,
// payload items sustain one beat per cycle and a header item yields 2 to 14 beats at one
// per cycle from the back end; the front keeps accepting until the entry queue (QUEUE_DEPTH) fills.
// Synchronous reset clears frame state, mask_enable, the queue and the output stage.
module websocket_frame_builder import wsfb_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // fin_bit, rsv1_bit, rsv2_bit, rsv3_bit, frame_opcode[3:0], payload_length[62:0],
  // mask_key[31:0], data_byte[7:0], one zero pad bit
  input  logic [S_TDATA_W-1:0] s_tdata,
  // func
  input  logic                 s_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_byte[7:0]
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  // frame_end
  output logic                 m_tuser
);

  logic        q_full;
  logic        push;
  wsfb_entry_t push_entry;
  logic        pop;
  logic        head_valid;
  wsfb_entry_t head;

  wsfb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  wsfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  wsfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
